// ===== sv/ddp_fp_pkg.sv =====
`default_nettype none
package ddp_fp_pkg;

  localparam int unsigned MaxPayloadDef = 1440;

  localparam int unsigned FcW      = 21;
  localparam int unsigned CppW     = 11;
  localparam int unsigned StartW   = 25;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OffW     = 26;
  localparam int unsigned SeqW     = 4;
  localparam int unsigned HdrIdxW  = 4;
  localparam int unsigned QDepth   = 2;

  localparam logic [CfgIdxW-1:0] RegFrameChannels    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChannelsPerPacket = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeepNumbers      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartChannel     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSyncMode         = 3'd4;

  localparam logic [7:0] FlagsBase = 8'h40;
  localparam logic [7:0] FlagPush  = 8'h01;
  localparam logic [7:0] DisplayId = 8'h01;

  localparam logic [SeqW-1:0] SeqFirst = 4'd1;
  localparam logic [SeqW-1:0] SeqLast  = 4'd15;

  localparam logic [HdrIdxW-1:0] HdrFlags  = 4'd0;
  localparam logic [HdrIdxW-1:0] HdrSeq    = 4'd1;
  localparam logic [HdrIdxW-1:0] HdrRsvd   = 4'd2;
  localparam logic [HdrIdxW-1:0] HdrId     = 4'd3;
  localparam logic [HdrIdxW-1:0] HdrOff3   = 4'd4;
  localparam logic [HdrIdxW-1:0] HdrOff2   = 4'd5;
  localparam logic [HdrIdxW-1:0] HdrOff1   = 4'd6;
  localparam logic [HdrIdxW-1:0] HdrOff0   = 4'd7;
  localparam logic [HdrIdxW-1:0] HdrLenHi  = 4'd8;
  localparam logic [HdrIdxW-1:0] HdrLenLo  = 4'd9;
  localparam logic [HdrIdxW-1:0] HdrCount  = 4'd10;

  typedef struct packed {
    logic [7:0]      data;
    logic            hdr;
    logic            push;
    logic [SeqW-1:0] seq;
    logic [OffW-1:0] off;
    logic [CppW-1:0] len;
    logic            eop;
    logic            eof;
  } entry_t;

  function automatic logic [7:0] hdr_byte(input logic [HdrIdxW-1:0] idx, input entry_t e);
    logic [31:0] off32;
    logic [15:0] len16;
    logic [7:0]  b;
    off32 = {{(32-OffW){1'b0}}, e.off};
    len16 = {{(16-CppW){1'b0}}, e.len};
    case (idx)
      HdrFlags: b = e.push ? (FlagsBase | FlagPush) : FlagsBase;
      HdrSeq:   b = {{(8-SeqW){1'b0}}, e.seq};
      HdrRsvd:  b = 8'h00;
      HdrId:    b = DisplayId;
      HdrOff3:  b = off32[31:24];
      HdrOff2:  b = off32[23:16];
      HdrOff1:  b = off32[15:8];
      HdrOff0:  b = off32[7:0];
      HdrLenHi: b = len16[15:8];
      HdrLenLo: b = len16[7:0];
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ddp_fp_front.sv =====
`default_nettype none
module ddp_fp_front #(
  parameter int unsigned MAX_PAYLOAD = ddp_fp_pkg::MaxPayloadDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ddp_fp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ddp_fp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [7:0]                         chan_byte_i,
  input  wire logic                               q_full_i,
  output logic                                    push_o,
  output ddp_fp_pkg::entry_t                      entry_o
);
  import ddp_fp_pkg::*;

  localparam int unsigned RemW = $clog2(MAX_PAYLOAD + 1);

  logic [FcW-1:0]    fc_q;
  logic [CppW-1:0]   cpp_q;
  logic              keep_q;
  logic [StartW-1:0] start_q;
  logic              sync_q;

  logic [FcW-1:0]    pos_q, pos_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [SeqW-1:0]   seq_q, seq_d;

  logic [FcW-1:0]    fc;
  logic [CppW-1:0]   cpp;
  logic              pkt_start;
  logic [FcW-1:0]    pos0;
  logic [FcW-1:0]    left;
  logic              fits;
  logic [CppW-1:0]   len;
  logic [StartW-1:0] base;
  logic [OffW-1:0]   off;
  logic [RemW-1:0]   rem_cur;
  logic [RemW-1:0]   rem_dec;
  logic [FcW:0]      pos_inc;
  logic              eof;
  logic              eop;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    fc = (fc_q == '0) ? FcW'(1) : fc_q;
    if (cpp_q == '0) begin
      cpp = CppW'(1);
    end else if (cpp_q > CppW'(MAX_PAYLOAD)) begin
      cpp = CppW'(MAX_PAYLOAD);
    end else begin
      cpp = cpp_q;
    end
    pkt_start = (rem_q == '0);
    pos0      = (pkt_start && (pos_q >= fc)) ? '0 : pos_q;
    left      = fc - pos0;
    fits      = (left <= {{(FcW-CppW){1'b0}}, cpp});
    len       = fits ? left[CppW-1:0] : cpp;
    base      = (keep_q && (start_q != '0)) ? (start_q - StartW'(1)) : '0;
    off       = {{(OffW-StartW){1'b0}}, base} + {{(OffW-FcW){1'b0}}, pos0};
    rem_cur   = pkt_start ? RemW'(len) : rem_q;
    rem_dec   = rem_cur - RemW'(1);
    pos_inc   = {1'b0, pos0} + (FcW+1)'(1);
    eof       = (pos_inc >= {1'b0, fc});
    eop       = eof || (rem_dec == '0);

    pos_d = eof ? '0 : pos_inc[FcW-1:0];
    rem_d = eof ? '0 : rem_dec;
    if (eop) begin
      seq_d = (seq_q >= SeqLast) ? SeqFirst : (seq_q + SeqW'(1));
    end else begin
      seq_d = seq_q;
    end

    entry_o.data = chan_byte_i;
    entry_o.hdr  = pkt_start;
    entry_o.push = !sync_q && fits;
    entry_o.seq  = seq_q;
    entry_o.off  = off;
    entry_o.len  = len;
    entry_o.eop  = eop;
    entry_o.eof  = eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= FcW'(512);
      cpp_q   <= CppW'(1440);
      keep_q  <= 1'b1;
      start_q <= StartW'(1);
      sync_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameChannels:     fc_q    <= cfg_data_i[FcW-1:0];
        RegChannelsPerPacket: cpp_q   <= cfg_data_i[CppW-1:0];
        RegKeepNumbers:       keep_q  <= cfg_data_i[0];
        RegStartChannel:      start_q <= cfg_data_i[StartW-1:0];
        RegSyncMode:          sync_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rem_q <= '0;
      seq_q <= SeqFirst;
    end else if (push_o) begin
      pos_q <= pos_d;
      rem_q <= rem_d;
      seq_q <= seq_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddp_fp_queue.sv =====
`default_nettype none
module ddp_fp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ddp_fp_pkg::entry_t  entry_i,
  output logic                     full_o,
  output logic                     valid_o,
  output ddp_fp_pkg::entry_t       head_o,
  input  wire logic                pop_i
);
  import ddp_fp_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  entry_t          mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : (p + PtrW'(1));
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddp_fp_back.sv =====
`default_nettype none
module ddp_fp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire ddp_fp_pkg::entry_t  head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               out_byte_o,
  output logic                     is_header_o,
  output logic                     end_of_packet_o,
  output logic                     end_of_frame_o,
  output logic                     last_of_run_o
);
  import ddp_fp_pkg::*;

  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic               vld_q, vld_d;
  logic [7:0]         byte_q, byte_d;
  logic               hdr_q, hdr_d;
  logic               eop_q, eop_d;
  logic               eof_q, eof_d;
  logic               last_q, last_d;

  logic load;
  logic emit_hdr;

  assign load     = head_valid_i && (!vld_q || !out_stall_i);
  assign emit_hdr = head_i.hdr && (idx_q != HdrCount);
  assign pop_o    = load && !emit_hdr;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && out_stall_i;
    byte_d = byte_q;
    hdr_d  = hdr_q;
    eop_d  = eop_q;
    eof_d  = eof_q;
    last_d = last_q;
    if (load) begin
      vld_d = 1'b1;
      if (emit_hdr) begin
        byte_d = hdr_byte(idx_q, head_i);
        hdr_d  = 1'b1;
        eop_d  = 1'b0;
        eof_d  = 1'b0;
        last_d = 1'b0;
        idx_d  = idx_q + HdrIdxW'(1);
      end else begin
        byte_d = head_i.data;
        hdr_d  = 1'b0;
        eop_d  = head_i.eop;
        eof_d  = head_i.eof;
        last_d = 1'b1;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    eop_q  <= eop_d;
    eof_q  <= eof_d;
    last_q <= last_d;
  end

  assign out_valid_o     = vld_q;
  assign out_byte_o      = byte_q;
  assign is_header_o     = hdr_q;
  assign end_of_packet_o = eop_q;
  assign end_of_frame_o  = eof_q;
  assign last_of_run_o   = last_q;

endmodule
`default_nettype wire

// ===== sv/ddp_frame_packetizer.sv =====
// An accepted request is written into the queue and then loaded into the output
// register; a packet's first payload byte is preceded by ten header bytes.
// Throughput: one payload byte per cycle while not stalled, plus ten header bytes
// per packet, set by the single byte-wide output register draining the two-entry queue.
// Reset (async, active low): registers to defaults, position 0, sequence 1, queue empty.
`default_nettype none
module ddp_frame_packetizer #(
  parameter int unsigned MAX_PAYLOAD = ddp_fp_pkg::MaxPayloadDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ddp_fp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ddp_fp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      chan_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 is_header_o,
  output logic                                 end_of_packet_o,
  output logic                                 end_of_frame_o,
  output logic                                 last_of_run_o
);
  import ddp_fp_pkg::*;

  logic   push;
  entry_t entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   pop;

  ddp_fp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .chan_byte_i(chan_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  ddp_fp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (q_head),
    .pop_i  (pop)
  );

  ddp_fp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .is_header_o    (is_header_o),
    .end_of_packet_o(end_of_packet_o),
    .end_of_frame_o (end_of_frame_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== sv/ddp_fp_checker.sv =====
`default_nettype none
module ddp_fp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       is_header_o,
  input wire logic       end_of_packet_o,
  input wire logic       end_of_frame_o,
  input wire logic       last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(is_header_o))
    else $error("stalled output changed");

  a_hdr_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> !end_of_packet_o && !end_of_frame_o && !last_of_run_o)
    else $error("header byte carries payload markers");

  a_payload_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_header_o |-> last_of_run_o)
    else $error("payload byte not last of run");

  a_eof_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_packet_o)
    else $error("frame end without packet end");

endmodule

bind ddp_frame_packetizer ddp_fp_checker u_ddp_fp_checker (.*);
`default_nettype wire
